FILE: rtl/slpa_pkg.sv
// ----------------------------------------------------------------------------
// slpa_pkg
// Shared types, opcodes and register codes of the sensor link pairing and
// acknowledge unit.
// ----------------------------------------------------------------------------
package slpa_pkg;

   // Radio packet opcodes.
   localparam logic [7:0] OP_DATA         = 8'h00;
   localparam logic [7:0] OP_PAIR_REQUEST = 8'h01;
   localparam logic [7:0] OP_DATA_ACK     = 8'h80;
   localparam logic [7:0] OP_PAIR_REPLY   = 8'h81;

   // Register reset values.
   localparam logic [7:0]  BASE_ID_RST     = 8'd0;
   localparam logic [15:0] CAL_PERIOD_RST  = 16'd1000;
   localparam logic [7:0]  RETRY_TICKS_RST = 8'd100;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_PACKET    = 2'd1,
      MODE_PAIR_ON   = 2'd2,
      MODE_PAIR_OFF  = 2'd3
   } mode_type;

   // Word index of each configuration register.
   typedef enum logic [1:0] {
      REG_BASE_ID     = 2'd0,
      REG_CAL_PERIOD  = 2'd1,
      REG_RETRY_TICKS = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  base_id;
      logic [15:0] calibration_period;
      logic [7:0]  retry_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] rx_base_id;
      logic [7:0] rx_sensor_id;
      logic [7:0] rx_opcode;
      logic [7:0] rx_temperature;
      logic [7:0] rx_battery;
   } evt_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_sensor_id;
      logic [7:0] tx_base_id;
      logic [7:0] tx_opcode;
      logic       recalibrate;
      logic       pairing_done;
      logic       reading_valid;
      logic [7:0] temperature;
      logic [7:0] battery;
      logic       pairing_active;
   } rslt_type;

endpackage

FILE: rtl/slpa_csr.sv
// ----------------------------------------------------------------------------
// slpa_csr
// APB-style configuration registers: base id, recalibration period and
// pairing retry period.
// ----------------------------------------------------------------------------
module slpa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [slpa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output slpa_pkg::cfg_type               cfg
);
   import slpa_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_BASE_ID:     cfg_in.base_id            = pwdata[7:0];
            REG_CAL_PERIOD:  cfg_in.calibration_period = pwdata[15:0];
            REG_RETRY_TICKS: cfg_in.retry_ticks        = pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_id            <= BASE_ID_RST;
         cfg_ff.calibration_period <= CAL_PERIOD_RST;
         cfg_ff.retry_ticks        <= RETRY_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_BASE_ID:     prdata = {24'd0, cfg_ff.base_id};
         REG_CAL_PERIOD:  prdata = {16'd0, cfg_ff.calibration_period};
         REG_RETRY_TICKS: prdata = {24'd0, cfg_ff.retry_ticks};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/slpa_core.sv
// ----------------------------------------------------------------------------
// slpa_core
// Link state (pairing flag, retry timer, recalibration counter, paired id and
// last reading) and the single-pass event logic that updates it.
// ----------------------------------------------------------------------------
module slpa_core (
   input  logic               clock,
   input  logic               reset,
   input  slpa_pkg::evt_type  evt,
   input  logic               evt_fire,
   input  slpa_pkg::cfg_type  cfg,
   output slpa_pkg::rslt_type rslt
);
   import slpa_pkg::*;

   logic        pairing_on_ff, pairing_on_in;
   logic [7:0]  retry_timer_ff, retry_timer_in;
   logic [15:0] cal_counter_ff, cal_counter_in;
   logic [7:0]  sensor_id_ff, sensor_id_in;
   logic [7:0]  temperature_ff, temperature_in;
   logic [7:0]  battery_ff, battery_in;

   logic [16:0] cal_next;
   logic [7:0]  retry_dec;
   logic        base_match;
   logic        tx;
   logic [7:0]  tx_op;

   assign cal_next   = {1'b0, cal_counter_ff} + 17'd1;
   assign retry_dec  = retry_timer_ff - 8'd1;
   assign base_match = (evt.rx_base_id == cfg.base_id);

   always_comb begin
      pairing_on_in  = pairing_on_ff;
      retry_timer_in = retry_timer_ff;
      cal_counter_in = cal_counter_ff;
      sensor_id_in   = sensor_id_ff;
      temperature_in = temperature_ff;
      battery_in     = battery_ff;
      tx             = 1'b0;
      tx_op          = OP_DATA;
      rslt           = '0;

      unique case (evt.mode)
         MODE_TICK: begin
            // The counter carries one extra bit so a period of 65535 still wraps.
            if (cal_next > {1'b0, cfg.calibration_period}) begin
               cal_counter_in   = 16'd0;
               rslt.recalibrate = 1'b1;
            end else begin
               cal_counter_in = cal_next[15:0];
            end
            if (retry_timer_ff != 8'd0) begin
               if (retry_dec == 8'd0) begin
                  tx             = 1'b1;
                  tx_op          = OP_PAIR_REQUEST;
                  retry_timer_in = cfg.retry_ticks;
               end else begin
                  retry_timer_in = retry_dec;
               end
            end
         end
         MODE_PACKET: begin
            if (pairing_on_ff) begin
               if (base_match && evt.rx_opcode == OP_PAIR_REPLY) begin
                  sensor_id_in      = evt.rx_sensor_id;
                  rslt.pairing_done = 1'b1;
                  retry_timer_in    = 8'd0;
                  pairing_on_in     = 1'b0;
               end
            end else if (base_match && evt.rx_sensor_id == sensor_id_ff &&
                         evt.rx_opcode == OP_DATA) begin
               temperature_in     = evt.rx_temperature;
               battery_in         = evt.rx_battery;
               rslt.reading_valid = 1'b1;
               tx                 = 1'b1;
               tx_op              = OP_DATA_ACK;
            end
         end
         MODE_PAIR_ON: begin
            pairing_on_in  = 1'b1;
            tx             = 1'b1;
            tx_op          = OP_PAIR_REQUEST;
            retry_timer_in = cfg.retry_ticks;
         end
         default: begin
            pairing_on_in  = 1'b0;
            retry_timer_in = 8'd0;
         end
      endcase

      rslt.tx_valid       = tx;
      rslt.tx_sensor_id   = tx ? sensor_id_ff : 8'd0;
      rslt.tx_base_id     = tx ? cfg.base_id : 8'd0;
      rslt.tx_opcode      = tx ? tx_op : 8'd0;
      rslt.temperature    = temperature_in;
      rslt.battery        = battery_in;
      rslt.pairing_active = pairing_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairing_on_ff  <= 1'b0;
         retry_timer_ff <= 8'd0;
         cal_counter_ff <= 16'd0;
         sensor_id_ff   <= 8'd0;
         temperature_ff <= 8'd0;
         battery_ff     <= 8'd0;
      end else if (evt_fire) begin
         pairing_on_ff  <= pairing_on_in;
         retry_timer_ff <= retry_timer_in;
         cal_counter_ff <= cal_counter_in;
         sensor_id_ff   <= sensor_id_in;
         temperature_ff <= temperature_in;
         battery_ff     <= battery_in;
      end
   end

endmodule

FILE: rtl/sensor_link_pairing_and_ack_unit.sv
// ----------------------------------------------------------------------------
// sensor_link_pairing_and_ack_unit
// Base-station side of a sensor radio link: pairing, data acknowledge and
// periodic radio recalibration requests.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the req_ channel (valid/ready): a tick, a received packet,
// pairing on or pairing off. Each accepted transaction yields exactly one
// result transaction on the rsp_ channel, carrying the packet to transmit
// (if any), the recalibration request, pairing and reading status.
// A transaction is captured in the input register on acceptance, processed
// against the link state as it moves on and placed in the result register,
// which raises rsp_valid. Throughput is one transaction per cycle while the
// receiver does not hold rsp_ready low; the link state is updated as each
// transaction moves from the input register to the result register, so
// consecutive transactions see each other's effects.
// When the receiver holds rsp_ready low, the result register keeps its
// value, the input register fills and req_ready then drops.
// Synchronous reset empties both registers and restores the link state
// and the csr_ registers to their defaults (base id 0, period 1000, retry
// 100). Configuration is meant to change only while the unit is idle.
// ----------------------------------------------------------------------------
module sensor_link_pairing_and_ack_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [7:0]                      req_rx_base_id,
   input  logic [7:0]                      req_rx_sensor_id,
   input  logic [7:0]                      req_rx_opcode,
   input  logic [7:0]                      req_rx_temperature,
   input  logic [7:0]                      req_rx_battery,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_sensor_id,
   output logic [7:0]                      rsp_tx_base_id,
   output logic [7:0]                      rsp_tx_opcode,
   output logic                            rsp_recalibrate,
   output logic                            rsp_pairing_done,
   output logic                            rsp_reading_valid,
   output logic [7:0]                      rsp_temperature,
   output logic [7:0]                      rsp_battery,
   output logic                            rsp_pairing_active,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [slpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import slpa_pkg::*;

   cfg_type  cfg;
   evt_type  evt_ff;
   evt_type  evt_in;
   logic     evt_valid_ff;
   logic     evt_valid_in;
   rslt_type rslt;
   rslt_type rslt_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     advance;
   logic     req_fire;

   slpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // The input register moves on whenever the result register is empty or
   // is being drained in this cycle.
   assign advance   = evt_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !evt_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      evt_in.mode           = mode_type'(req_mode);
      evt_in.rx_base_id     = req_rx_base_id;
      evt_in.rx_sensor_id   = req_rx_sensor_id;
      evt_in.rx_opcode      = req_rx_opcode;
      evt_in.rx_temperature = req_rx_temperature;
      evt_in.rx_battery     = req_rx_battery;
      evt_valid_in          = req_fire || (evt_valid_ff && !advance);
      rsp_valid_in          = advance || (rsp_valid_ff && !rsp_ready);
   end

   slpa_core u_core (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt_ff),
      .evt_fire (advance),
      .cfg      (cfg),
      .rslt     (rslt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         evt_ff <= evt_in;
      end
      if (advance) begin
         rslt_ff <= rslt;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_valid       = rslt_ff.tx_valid;
   assign rsp_tx_sensor_id   = rslt_ff.tx_sensor_id;
   assign rsp_tx_base_id     = rslt_ff.tx_base_id;
   assign rsp_tx_opcode      = rslt_ff.tx_opcode;
   assign rsp_recalibrate    = rslt_ff.recalibrate;
   assign rsp_pairing_done   = rslt_ff.pairing_done;
   assign rsp_reading_valid  = rslt_ff.reading_valid;
   assign rsp_temperature    = rslt_ff.temperature;
   assign rsp_battery        = rslt_ff.battery;
   assign rsp_pairing_active = rslt_ff.pairing_active;

   // A transmitted packet is either a pairing request or a data acknowledge.
   a_tx_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |->
         (rsp_tx_opcode == OP_PAIR_REQUEST || rsp_tx_opcode == OP_DATA_ACK))
      else $error("transmit opcode is neither pairing request nor acknowledge");

   // No transmit packet means all packet bytes read zero.
   a_tx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |->
         (rsp_tx_opcode == 8'd0 && rsp_tx_sensor_id == 8'd0 && rsp_tx_base_id == 8'd0))
      else $error("packet bytes nonzero without a transmit");

   // Completing pairing ends pairing mode and sends nothing.
   a_pair_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pairing_done |-> !rsp_pairing_active && !rsp_tx_valid)
      else $error("pairing completion left pairing active or sent a packet");

   // Each accepted reading is acknowledged in the same transaction.
   a_reading_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reading_valid |->
         rsp_tx_valid && rsp_tx_opcode == OP_DATA_ACK && !rsp_pairing_active)
      else $error("reading accepted without a data acknowledge");

endmodule
